// ===== hdl/spd_pkg.sv =====
// Package: types, constants and codes shared by the sensor packet deframer files.
package spd_pkg;

   localparam int BYTE_W       = 8;
   localparam int POS_W        = 9;
   localparam int LEN_W        = 16;
   localparam int SUM_W        = 16;
   localparam int CFG_LEN_W    = 9;
   localparam int STATUS_W     = 3;
   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 9;

   localparam int MAX_PAYLOAD_DEFAULT = 256;

   localparam logic [BYTE_W-1:0] START_HI = 8'hEF;
   localparam logic [BYTE_W-1:0] START_LO = 8'h01;
   localparam logic [BYTE_W-1:0] KIND_ACK = 8'h07;
   localparam logic [BYTE_W-1:0] KIND_END = 8'h08;

   // Byte positions within a frame.
   localparam logic [POS_W-1:0] POS_START_HI      = 9'd0;
   localparam logic [POS_W-1:0] POS_START_LO      = 9'd1;
   localparam logic [POS_W-1:0] POS_ADDR_LAST     = 9'd5;
   localparam logic [POS_W-1:0] POS_KIND          = 9'd6;
   localparam logic [POS_W-1:0] POS_LEN_HI        = 9'd7;
   localparam logic [POS_W-1:0] POS_LEN_LO        = 9'd8;
   localparam logic [POS_W-1:0] POS_FIRST_PAYLOAD = 9'd9;
   localparam logic [POS_W-1:0] PAYLOAD_END_OFS   = 9'd6;

   localparam logic [LEN_W-1:0] MIN_LENGTH      = 16'd3;
   localparam logic [LEN_W-1:0] LENGTH_OVERHEAD = 16'd2;

   localparam logic [CFG_LEN_W-1:0] MAX_PAYLOAD_LEN_RESET  = 9'd128;
   localparam logic                 CHECK_START_WORD_RESET = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 3'd0,
      ST_CHECKSUM   = 3'd1,
      ST_BAD_START  = 3'd2,
      ST_BAD_LENGTH = 3'd3,
      ST_ACK_ERROR  = 3'd4
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_MAX_PAYLOAD_LEN  = 1'b0,
      REG_CHECK_START_WORD = 1'b1
   } reg_index_type;

   typedef enum logic {
      KIND_PAYLOAD = 1'b0,
      KIND_STATUS  = 1'b1
   } result_kind_type;

   typedef struct packed {
      result_kind_type   result_kind;
      logic [BYTE_W-1:0] payload_byte;
      logic              last_payload;
      logic [BYTE_W-1:0] packet_kind;
      status_type        frame_status;
      logic [BYTE_W-1:0] confirm_code;
      logic              end_packet;
   } result_type;

endpackage

// ===== hdl/spd_req_if.sv =====
// Interface: received-byte channel (valid/ready plus one byte).
interface spd_req_if;
   logic                            valid;
   logic                            ready;
   logic [spd_pkg::BYTE_W-1:0]      rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== hdl/spd_rsp_if.sv =====
// Interface: result channel carrying payload bytes and frame status beats.
interface spd_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            result_kind;
   logic [spd_pkg::BYTE_W-1:0]      payload_byte;
   logic                            last_payload;
   logic [spd_pkg::BYTE_W-1:0]      packet_kind;
   logic [spd_pkg::STATUS_W-1:0]    frame_status;
   logic [spd_pkg::BYTE_W-1:0]      confirm_code;
   logic                            end_packet;

   modport source (output valid, output result_kind, output payload_byte,
                   output last_payload, output packet_kind, output frame_status,
                   output confirm_code, output end_packet, input ready);
   modport sink   (input valid, input result_kind, input payload_byte,
                   input last_payload, input packet_kind, input frame_status,
                   input confirm_code, input end_packet, output ready);
endinterface

// ===== hdl/spd_csr_if.sv =====
// Interface: configuration register write channel.
interface spd_csr_if;
   logic                               valid;
   logic                               ready;
   logic [spd_pkg::CSR_INDEX_W-1:0]    index;
   logic [spd_pkg::CSR_DATA_W-1:0]     wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ===== hdl/sensor_packet_deframer_unit.sv =====
// Top level: serial packet deframer with 16-bit additive checksum.
// A result beat is registered and appears on rsp in the cycle after the byte that causes it.
// Throughput: one byte per cycle; frame parse state and the result register are
// updated in the same cycle, so only a stalled result register holds off req.
// Reset (synchronous, active high): parser waits for a start word, hunting off,
// max_payload_len = 128, check_start_word = 1, no result pending.
module sensor_packet_deframer_unit #(
   parameter int MAX_PAYLOAD = spd_pkg::MAX_PAYLOAD_DEFAULT
) (
   input logic         clock,
   input logic         reset,
   spd_req_if.sink     req_bus,
   spd_rsp_if.source   rsp_bus,
   spd_csr_if.sink     csr_bus
);

   // Payload limit ceiling, sized to the config register.
   localparam logic [spd_pkg::CFG_LEN_W-1:0] LIMIT_CAP = spd_pkg::CFG_LEN_W'(MAX_PAYLOAD);

   // Configuration registers.
   logic [spd_pkg::CFG_LEN_W-1:0] max_len_ff;
   logic                          check_ff;

   // Parser state.
   logic [spd_pkg::POS_W-1:0]     pos_ff, pos_in;
   logic                          hunt_ff, hunt_in;
   logic [spd_pkg::SUM_W-1:0]     sum_ff, sum_in;
   logic [spd_pkg::BYTE_W-1:0]    kind_ff, kind_in;
   logic [spd_pkg::BYTE_W-1:0]    len_hi_ff, len_hi_in;
   logic [spd_pkg::POS_W-1:0]     end_pos_ff, end_pos_in;
   logic [spd_pkg::BYTE_W-1:0]    first_ff, first_in;
   logic [spd_pkg::BYTE_W-1:0]    cks_hi_ff, cks_hi_in;

   // Result register.
   logic                          rsp_valid_ff;
   spd_pkg::result_type           rsp_ff;

   // Per-byte combinational results.
   logic                          res_valid;
   spd_pkg::result_type           res;
   logic                          req_fire;
   logic                          proceed;
   logic [spd_pkg::POS_W-1:0]     pos;
   logic [spd_pkg::LEN_W-1:0]     length;
   logic [spd_pkg::CFG_LEN_W-1:0] limit;
   logic [spd_pkg::SUM_W-1:0]     sum_add;
   logic [spd_pkg::SUM_W-1:0]     received;
   logic                          is_ack;
   logic [spd_pkg::BYTE_W-1:0]    b;

   // Take a new byte whenever the result register is empty or draining.
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   assign b       = req_bus.rx_byte;
   assign sum_add = sum_ff + {{(spd_pkg::SUM_W - spd_pkg::BYTE_W){1'b0}}, b};
   assign limit   = (max_len_ff > LIMIT_CAP) ? LIMIT_CAP : max_len_ff;
   assign length  = {len_hi_ff, b};
   assign received = {cks_hi_ff, b};
   assign is_ack  = (kind_ff == spd_pkg::KIND_ACK);

   // Frame parser: next state and the result beat caused by this byte.
   always_comb begin
      pos_in     = pos_ff;
      hunt_in    = hunt_ff;
      sum_in     = sum_ff;
      kind_in    = kind_ff;
      len_hi_in  = len_hi_ff;
      end_pos_in = end_pos_ff;
      first_in   = first_ff;
      cks_hi_in  = cks_hi_ff;
      res_valid  = 1'b0;
      res        = '0;
      proceed    = 1'b1;
      pos        = pos_ff;

      // Hunting: drop bytes until a start byte, or resume at once with the check off.
      if (hunt_ff) begin
         if (!check_ff) begin
            hunt_in = 1'b0;
            pos     = spd_pkg::POS_START_HI;
            pos_in  = spd_pkg::POS_START_HI;
         end else if (b == spd_pkg::START_HI) begin
            hunt_in = 1'b0;
            sum_in  = '0;
            pos_in  = spd_pkg::POS_START_LO;
            proceed = 1'b0;
         end else begin
            proceed = 1'b0;
         end
      end

      if (proceed) begin
         priority if (pos == spd_pkg::POS_START_HI) begin
            sum_in = '0;
            if (check_ff && b != spd_pkg::START_HI) begin
               hunt_in            = 1'b1;
               res_valid          = 1'b1;
               res.result_kind    = spd_pkg::KIND_STATUS;
               res.frame_status   = spd_pkg::ST_BAD_START;
            end else begin
               pos_in = spd_pkg::POS_START_LO;
            end
         end else if (pos == spd_pkg::POS_START_LO) begin
            if (check_ff && b != spd_pkg::START_LO) begin
               hunt_in            = 1'b1;
               pos_in             = spd_pkg::POS_START_HI;
               res_valid          = 1'b1;
               res.result_kind    = spd_pkg::KIND_STATUS;
               res.frame_status   = spd_pkg::ST_BAD_START;
            end else begin
               pos_in = pos + 9'd1;
            end
         end else if (pos <= spd_pkg::POS_ADDR_LAST) begin
            // Skip the address bytes.
            pos_in = pos + 9'd1;
         end else if (pos == spd_pkg::POS_KIND) begin
            kind_in = b;
            sum_in  = sum_add;
            pos_in  = spd_pkg::POS_LEN_HI;
         end else if (pos == spd_pkg::POS_LEN_HI) begin
            len_hi_in = b;
            sum_in    = sum_add;
            pos_in    = spd_pkg::POS_LEN_LO;
         end else if (pos == spd_pkg::POS_LEN_LO) begin
            sum_in = sum_add;
            if (length < spd_pkg::MIN_LENGTH ||
                length > ({{(spd_pkg::LEN_W - spd_pkg::CFG_LEN_W){1'b0}}, limit}
                          + spd_pkg::LENGTH_OVERHEAD)) begin
               pos_in           = spd_pkg::POS_START_HI;
               hunt_in          = check_ff;
               res_valid        = 1'b1;
               res.result_kind  = spd_pkg::KIND_STATUS;
               res.packet_kind  = kind_ff;
               res.frame_status = spd_pkg::ST_BAD_LENGTH;
            end else begin
               // Length is known small here; its low bits locate the last payload byte.
               end_pos_in = length[spd_pkg::POS_W-1:0] + spd_pkg::PAYLOAD_END_OFS;
               pos_in     = spd_pkg::POS_FIRST_PAYLOAD;
            end
         end else if (pos <= end_pos_ff) begin
            // Pass the payload byte through and fold it into the checksum.
            sum_in = sum_add;
            if (pos == spd_pkg::POS_FIRST_PAYLOAD) begin
               first_in = b;
            end
            res_valid        = 1'b1;
            res.result_kind  = spd_pkg::KIND_PAYLOAD;
            res.payload_byte = b;
            res.last_payload = (pos == end_pos_ff);
            res.packet_kind  = kind_ff;
            pos_in           = pos + 9'd1;
         end else if (pos == end_pos_ff + 9'd1) begin
            cks_hi_in = b;
            pos_in    = pos + 9'd1;
         end else begin
            // Low checksum byte: close the frame.
            pos_in           = spd_pkg::POS_START_HI;
            hunt_in          = 1'b0;
            res_valid        = 1'b1;
            res.result_kind  = spd_pkg::KIND_STATUS;
            res.packet_kind  = kind_ff;
            priority if (received != sum_ff) begin
               res.frame_status = spd_pkg::ST_CHECKSUM;
            end else if (is_ack && first_ff != '0) begin
               res.frame_status = spd_pkg::ST_ACK_ERROR;
            end else begin
               res.frame_status = spd_pkg::ST_OK;
            end
            res.confirm_code = is_ack ? first_ff : '0;
            res.end_packet   = (kind_ff == spd_pkg::KIND_END);
         end
      end
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= spd_pkg::MAX_PAYLOAD_LEN_RESET;
         check_ff   <= spd_pkg::CHECK_START_WORD_RESET;
      end else if (csr_bus.valid && csr_bus.ready) begin
         unique case (spd_pkg::reg_index_type'(csr_bus.index))
            spd_pkg::REG_MAX_PAYLOAD_LEN: begin
               max_len_ff <= csr_bus.wdata[spd_pkg::CFG_LEN_W-1:0];
            end
            spd_pkg::REG_CHECK_START_WORD: begin
               check_ff <= csr_bus.wdata[0];
            end
            default: begin
               max_len_ff <= max_len_ff;
            end
         endcase
      end
   end

   // Parser state: advance only on an accepted byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= spd_pkg::POS_START_HI;
         hunt_ff    <= 1'b0;
         sum_ff     <= '0;
         kind_ff    <= '0;
         len_hi_ff  <= '0;
         end_pos_ff <= '0;
         first_ff   <= '0;
         cks_hi_ff  <= '0;
      end else if (req_fire) begin
         pos_ff     <= pos_in;
         hunt_ff    <= hunt_in;
         sum_ff     <= sum_in;
         kind_ff    <= kind_in;
         len_hi_ff  <= len_hi_in;
         end_pos_ff <= end_pos_in;
         first_ff   <= first_in;
         cks_hi_ff  <= cks_hi_in;
      end
   end

   // Result register: load on an accepted byte, drop once the sink takes the beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= res_valid;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= res;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.result_kind  = rsp_ff.result_kind;
   assign rsp_bus.payload_byte = rsp_ff.payload_byte;
   assign rsp_bus.last_payload = rsp_ff.last_payload;
   assign rsp_bus.packet_kind  = rsp_ff.packet_kind;
   assign rsp_bus.frame_status = rsp_ff.frame_status;
   assign rsp_bus.confirm_code = rsp_ff.confirm_code;
   assign rsp_bus.end_packet   = rsp_ff.end_packet;

endmodule
